/* hw/rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared state type, command and status structs, round constants and helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       absorb;
        logic       load;
        logic       round;
        logic       fold;
        logic       pad_mark;
        logic       finish;
        logic       take_end;
    } ctrl_t;

    typedef struct packed {
        logic       block_full;
        logic       last_round;
        logic       end_pending;
        logic       pad_long;
        logic [5:0] pad_pos;
    } stat_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hw/rtl/sha256_hash_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 hash core
// Streaming SHA-256 engine, at most one message byte per input item.
// ----------------------------------------------------------------------------
// Input channel s_axis: tdata = data_byte, tuser = has_byte,
// tlast = end_of_message. An item with has_byte set adds one byte; an item
// with end_of_message set pads the message and hashes it, also when no byte
// has been seen.
// Output channel m_axis: tdata = {word_index, digest_word}, tlast = last_word.
// Eight items follow each end of message, digest word 0 first.
// Throughput: one byte per cycle while the block buffer fills; the 64th
// byte of a block starts a compression (load, the rounds of the single
// round unit, chain fold), during which no input item is taken.
// After the end item the core pads, compresses and emits the digest. A
// block filled by the end item is compressed before the padding; padding
// takes a second block when the last block holds more than 55 bytes.
// Reset returns the initial hash values and a zero byte count.
// A stalled receiver holds the current digest word; no input item is
// taken until all eight words have been delivered.
// ----------------------------------------------------------------------------
module sha256_hash_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast
);

    sha256_pkg::ctrl_t ctrl;
    sha256_pkg::stat_t stat;
    logic        in_fire, out_fire;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {5'd0, word_index, digest_word};

    sha256_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_has    (s_axis_tuser),
        .in_end    (s_axis_tlast),
        .out_fire  (out_fire),
        .out_last  (m_axis_tlast),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    sha256_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_axis_tdata),
        .ctrl        (ctrl),
        .out_fire    (out_fire),
        .stat        (stat),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_axis_tlast)
    );

endmodule

/* hw/rtl/sha256_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               in_has,
    input  logic               in_end,
    input  logic               out_fire,
    input  logic               out_last,
    input  sha256_pkg::stat_t  stat,
    output sha256_pkg::ctrl_t  ctrl,
    output logic               in_ready,
    output logic               out_valid
);

    sha256_pkg::state_t state_reg, state_next;
    logic               pad_done_reg, pad_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            pad_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pad_done_reg <= pad_done_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pad_done_next = pad_done_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_fire && in_has && stat.block_full)
                begin
                    state_next    = sha256_pkg::ST_LOAD;
                    pad_done_next = 1'b0;
                end
                else if (in_fire && in_end)
                begin
                    state_next    = sha256_pkg::ST_PAD;
                    pad_done_next = 1'b0;
                end
            end
            sha256_pkg::ST_LOAD:
                state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (stat.last_round)
                    state_next = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD:
            begin
                if (stat.end_pending && pad_done_reg)
                    state_next = sha256_pkg::ST_EMIT;
                else if (stat.end_pending)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD:
            begin
                if (stat.pad_pos == 6'd63)
                begin
                    state_next    = sha256_pkg::ST_LOAD;
                    pad_done_next = !stat.pad_long;
                end
            end
            sha256_pkg::ST_EMIT:
                if (out_fire && out_last)
                    state_next = sha256_pkg::ST_IDLE;
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                ctrl.absorb   = in_fire && in_has;
                ctrl.take_end = in_fire && in_end;
            end
            sha256_pkg::ST_LOAD:  ctrl.load     = 1'b1;
            sha256_pkg::ST_ROUND: ctrl.round    = 1'b1;
            sha256_pkg::ST_FOLD:  ctrl.fold     = 1'b1;
            sha256_pkg::ST_PAD:   ctrl.pad_mark = 1'b1;
            sha256_pkg::ST_EMIT:
            begin
                out_valid   = 1'b1;
                ctrl.finish = out_fire && out_last;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/sha256_dpath.sv */
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, schedule window, working variables, chaining words and count.
// ----------------------------------------------------------------------------
module sha256_dpath
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_byte,
    input  sha256_pkg::ctrl_t  ctrl,
    input  logic               out_fire,
    output sha256_pkg::stat_t  stat,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);

    logic [31:0] blk_reg [16];
    logic [31:0] w_reg   [16];
    logic [31:0] v_reg   [8];
    logic [31:0] h_reg   [8];
    logic [60:0] total_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pad_reg;
    logic        mark_reg;
    logic        end_reg;
    logic        long_reg;
    logic [2:0]  idx_reg;

    logic [31:0] w_new, w_cur, t1, t2, e, a;
    logic [5:0]  fill;
    logic [4:0]  fill_lane, pad_lane;
    logic [5:0]  len_lane;

    assign fill      = total_reg[5:0];
    assign e         = v_reg[4];
    assign a         = v_reg[0];
    assign fill_lane = {~fill[1:0], 3'b000};
    assign pad_lane  = {~pad_reg[1:0], 3'b000};
    assign len_lane  = {~pad_reg[2:0], 3'b000};

    always_comb
    begin
        w_new = w_reg[0]
              + (sha256_pkg::ror(w_reg[1], 7) ^ sha256_pkg::ror(w_reg[1], 18)
                 ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (sha256_pkg::ror(w_reg[14], 17) ^ sha256_pkg::ror(w_reg[14], 19)
                 ^ (w_reg[14] >> 10));
        w_cur = w_reg[0];
        t1 = v_reg[7]
           + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6]))
           + sha256_pkg::K_ROUND[rnd_reg] + w_cur;
        t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign stat.block_full  = (fill == 6'd63);
    assign stat.last_round  = (rnd_reg == 6'd63);
    assign stat.end_pending = end_reg;
    assign stat.pad_long    = long_reg;
    assign stat.pad_pos     = pad_reg;

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (ctrl.absorb)
            blk_reg[fill[5:2]][fill_lane +: 8] <= in_byte;
        if (ctrl.pad_mark)
        begin
            if (pad_reg >= 6'd56 && !long_reg)
                blk_reg[pad_reg[5:2]][pad_lane +: 8] <= bits_reg[len_lane +: 8];
            else if (mark_reg && pad_reg == fill)
                blk_reg[pad_reg[5:2]][pad_lane +: 8] <= sha256_pkg::PAD_MARK;
            else if (!mark_reg || pad_reg > fill)
                blk_reg[pad_reg[5:2]][pad_lane +: 8] <= 8'h00;
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk_reg[i];
        end
        else if (ctrl.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::H_INIT[i];
                v_reg[i] <= '0;
            end
            total_reg <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            pad_reg   <= '0;
            mark_reg  <= 1'b0;
            end_reg   <= 1'b0;
            long_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ctrl.absorb)
                total_reg <= total_reg + 61'd1;
            if (ctrl.take_end)
                end_reg <= 1'b1;
            if (ctrl.load)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
                rnd_reg <= '0;
            end
            if (ctrl.round)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
            end
            if (ctrl.fold)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                rnd_reg <= '0;
            end
            // first pad pass sets mark; long message needs second block
            if (ctrl.take_end)
            begin
                pad_reg  <= '0;
                mark_reg <= 1'b1;
            end
            if (ctrl.pad_mark)
            begin
                pad_reg <= pad_reg + 6'd1;
                if (pad_reg == 6'd63)
                begin
                    mark_reg <= 1'b0;
                    long_reg <= 1'b0;
                end
            end
            if (ctrl.take_end)
            begin
                bits_reg <= {(ctrl.absorb ? total_reg + 61'd1 : total_reg), 3'b000};
                long_reg <= ((ctrl.absorb ? fill + 6'd1 : fill) > 6'd55);
            end
            if (out_fire)
                idx_reg <= idx_reg + 3'd1;
            if (ctrl.finish)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha256_pkg::H_INIT[i];
                total_reg <= '0;
                end_reg   <= 1'b0;
            end
        end
    end

endmodule

/* tb/sha256_hash_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hash core testbench
// Streams messages byte by byte into the core and compares every digest
// word against an in-bench SHA-256 predictor, or against the typed digest
// of a directed row that gives one. Opens with a table of directed items,
// then runs random messages under several flow-control mixes.
module sha256_hash_core_test;

    localparam int LIMIT = 2000000;
    localparam int LENS[4] = '{55, 56, 63, 64};
    localparam int MIX_IDLE[4] = '{0, 78, 0, 18};
    localparam int MIX_STALL[4] = '{0, 0, 78, 18};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    typedef struct {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    int idle_pct;
    int stall_pct;
    int errors = 0;
    int cycles = 0;
    int words_seen = 0;
    int items_sent;

    digest_item_t digest_q[$];

    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    logic [60:0] nbytes;

    sha256_hash_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] s0;
        logic [31:0] s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        v = chain;
        for (int r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                s0 = rotr(w[(r+1)%16], 7) ^ rotr(w[(r+1)%16], 18) ^ (w[(r+1)%16] >> 3);
                s1 = rotr(w[(r+14)%16], 17) ^ rotr(w[(r+14)%16], 19)
                     ^ (w[(r+14)%16] >> 10);
                w[r%16] = w[r%16] + s0 + w[(r+9)%16] + s1;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K_ROUND[r] + w[r%16];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    // returns 1 with the digest when the item finishes a message
    function automatic logic hash_item(input logic [7:0] b, input logic has,
                                       input logic eom, output logic [255:0] dig);
        int          fill;
        logic [63:0] bits;
        dig = '0;
        if (has)
        begin
            fill = nbytes[5:0];
            blk[fill] = b;
            nbytes = nbytes + 61'd1;
            if (fill == 63)
                compress();
        end
        if (!eom)
            return 1'b0;
        fill = nbytes[5:0];
        bits = {nbytes, 3'b000};
        blk[fill] = sha256_pkg::PAD_MARK;
        fill++;
        if (fill > 56)
        begin
            while (fill < 64)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            compress();
            fill = 0;
        end
        while (fill < 56)
        begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (int i = 0; i < 8; i++)
            blk[56+i] = bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
            dig[255-32*i -: 32] = chain[i];
        chain = sha256_pkg::H_INIT;
        nbytes = '0;
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
                report("unexpected item", m_axis_tdata, '0);
            else
            begin
                automatic digest_item_t e = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== e.word)
                    report("digest_word", 40'(m_axis_tdata[31:0]), 40'(e.word));
                if (m_axis_tdata[34:32] !== e.idx)
                    report("word_index", 40'(m_axis_tdata[34:32]), 40'(e.idx));
                if (m_axis_tlast !== e.last)
                    report("last_word", 40'(m_axis_tlast), 40'(e.last));
            end
            words_seen++;
        end
    end

    task automatic send(input logic [7:0] b, input logic has, input logic eom,
                        input logic known, input logic [255:0] typed);
        logic         ok;
        logic [255:0] dig;
        digest_item_t e;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eom;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        items_sent++;
        if (hash_item(b, has, eom, dig))
        begin
            if (known)
                dig = typed;
            for (int i = 0; i < 8; i++)
            begin
                e.word = dig[255-32*i -: 32];
                e.idx  = 3'(i);
                e.last = (i == 7);
                digest_q.push_back(e);
            end
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (digest_q.size() != 0);
    endtask

    task automatic random_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            send(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1), 1'b0, '0);
        end
        if (s_axis_tlast !== 1'b1 || len == 0)
            send(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    endtask

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    stim_row_t table_rows[] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hff, 1'b0, 1'b0, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{8'hff, 1'b1, 1'b0, 1'b0, '0},
        '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b1, 1'b0, '0},
        '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hff, 1'b1, 1'b1, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST}
    };

    initial
    begin
        int n;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        chain         = sha256_pkg::H_INIT;
        nbytes        = '0;
        foreach (blk[i])
            blk[i] = 8'h00;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send(table_rows[i].data, table_rows[i].has, table_rows[i].eom,
                 table_rows[i].known, table_rows[i].digest);
        hold_until_drained();

        n = 0;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = MIX_IDLE[p];
            stall_pct = MIX_STALL[p];
            random_message(LENS[p]);
            while (items_sent < 15 + 55 * (p + 1) || words_seen < 16 * (p + 1))
            begin
                case ($urandom_range(9))
                    0:       n = $urandom_range(120, 135);
                    1, 2:    n = $urandom_range(50, 70);
                    default: n = $urandom_range(0, 20);
                endcase
                random_message(n);
            end
            if (p == 1)
                hold_until_drained();
        end
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
